>>> src/tvgs_pkg.sv
// tvgs_pkg: shared types, constants and helpers of the tv gradient shrinkage block
// used by every module in src; depends on nothing
package tvgs_pkg;

  localparam int DataWidth = 32;
  localparam int FracBits  = 16;
  localparam int IbWidth   = 48;
  localparam int SideW     = 2 * DataWidth + 3;
  localparam int SatInW    = DataWidth + 4;
  localparam int ApbDataW  = 64;
  localparam int ApbAddrW  = 4;

  localparam logic [IbWidth-1:0] IbReset = IbWidth'(67108864);

  // register index taken from paddr[3]
  localparam logic AddrInvBeta = 1'b0;
  localparam logic AddrMode    = 1'b1;

  localparam logic ModeIso   = 1'b0;
  localparam logic ModeAniso = 1'b1;

  typedef struct packed {
    logic signed [DataWidth-1:0] grad_h;
    logic signed [DataWidth-1:0] grad_v;
    logic signed [DataWidth-1:0] mult_h;
    logic signed [DataWidth-1:0] mult_v;
  } tvgs_in_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] shrunk_h;
    logic signed [DataWidth-1:0] shrunk_v;
    logic                        clipped;
  } tvgs_out_t;

  // saturate to DataWidth signed bits; msb of the result is the clip flag
  function automatic logic [DataWidth:0] sat_fn(input logic signed [SatInW-1:0] x);
    logic [SatInW-DataWidth:0] top;
    logic [DataWidth:0]        r;
    top = x[SatInW-1:DataWidth-1];
    if (top == '0 || top == '1) begin
      r = {1'b0, x[DataWidth-1:0]};
    end else if (x[SatInW-1]) begin
      r = {1'b1, 1'b1, {(DataWidth-1){1'b0}}};
    end else begin
      r = {1'b1, 1'b0, {(DataWidth-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

>>> src/tvgs_sqrt_cell.sv
// tvgs_sqrt_cell: one result bit of the pipelined integer square root
// depends on tvgs_pkg
module tvgs_sqrt_cell import tvgs_pkg::*; #(
  parameter int Idx = 0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [2*DataWidth-1:0]   x_i,
  input  logic [DataWidth+1:0]     rem_i,
  input  logic [DataWidth-1:0]     root_i,
  input  logic [SideW-1:0]         side_i,
  output logic                     valid_o,
  output logic [2*DataWidth-1:0]   x_o,
  output logic [DataWidth+1:0]     rem_o,
  output logic [DataWidth-1:0]     root_o,
  output logic [SideW-1:0]         side_o
);

  logic [DataWidth+3:0] rem_ext;
  logic [DataWidth+3:0] trial;
  logic                 ge;
  logic [DataWidth+3:0] rem_sub;
  logic                 valid_q;
  logic [2*DataWidth-1:0] x_q;
  logic [DataWidth+1:0] rem_q, rem_d;
  logic [DataWidth-1:0] root_q, root_d;
  logic [SideW-1:0]     side_q;

  assign rem_ext = {rem_i, x_i[2*Idx+1 -: 2]};
  assign trial   = (DataWidth+4)'({root_i, 2'b01});
  assign ge      = rem_ext >= trial;
  assign rem_sub = rem_ext - trial;
  assign rem_d   = ge ? rem_sub[DataWidth+1:0] : rem_ext[DataWidth+1:0];
  assign root_d  = {root_i[DataWidth-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_i;
      rem_q  <= rem_d;
      root_q <= root_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign side_o  = side_q;

endmodule

>>> src/tvgs_div_cell.sv
// tvgs_div_cell: one quotient bit of both restoring dividers, shared divisor
// depends on tvgs_pkg
module tvgs_div_cell import tvgs_pkg::*; #(
  parameter int Bit = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [DataWidth-1:0]   n_i,
  input  logic [2*DataWidth:0]   num_h_i,
  input  logic [2*DataWidth:0]   num_v_i,
  input  logic [DataWidth-1:0]   rem_h_i,
  input  logic [DataWidth-1:0]   rem_v_i,
  input  logic [DataWidth:0]     q_h_i,
  input  logic [DataWidth:0]     q_v_i,
  input  logic [SideW-1:0]       side_i,
  output logic                   valid_o,
  output logic [DataWidth-1:0]   n_o,
  output logic [2*DataWidth:0]   num_h_o,
  output logic [2*DataWidth:0]   num_v_o,
  output logic [DataWidth-1:0]   rem_h_o,
  output logic [DataWidth-1:0]   rem_v_o,
  output logic [DataWidth:0]     q_h_o,
  output logic [DataWidth:0]     q_v_o,
  output logic [SideW-1:0]       side_o
);

  logic [DataWidth:0]   rx_h, rx_v, nx, sub_h, sub_v;
  logic                 ge_h, ge_v;
  logic                 valid_q;
  logic [DataWidth-1:0] n_q, rem_h_q, rem_v_q;
  logic [2*DataWidth:0] num_h_q, num_v_q;
  logic [DataWidth:0]   q_h_q, q_v_q;
  logic [SideW-1:0]     side_q;

  assign nx    = {1'b0, n_i};
  assign rx_h  = {rem_h_i, num_h_i[Bit]};
  assign rx_v  = {rem_v_i, num_v_i[Bit]};
  assign ge_h  = rx_h >= nx;
  assign ge_v  = rx_v >= nx;
  assign sub_h = rx_h - nx;
  assign sub_v = rx_v - nx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q     <= n_i;
      num_h_q <= num_h_i;
      num_v_q <= num_v_i;
      rem_h_q <= ge_h ? sub_h[DataWidth-1:0] : rx_h[DataWidth-1:0];
      rem_v_q <= ge_v ? sub_v[DataWidth-1:0] : rx_v[DataWidth-1:0];
      q_h_q   <= {q_h_i[DataWidth-1:0], ge_h};
      q_v_q   <= {q_v_i[DataWidth-1:0], ge_v};
      side_q  <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign n_o     = n_q;
  assign num_h_o = num_h_q;
  assign num_v_o = num_v_q;
  assign rem_h_o = rem_h_q;
  assign rem_v_o = rem_v_q;
  assign q_h_o   = q_h_q;
  assign q_v_o   = q_v_q;
  assign side_o  = side_q;

endmodule

>>> src/tvgs_front.sv
// tvgs_front: shift term, saturated shifted vector, squares and squared norm
// depends on tvgs_pkg; feeds the square-root cell row
module tvgs_front import tvgs_pkg::*; #(
  parameter int FRAC_BITS = FracBits
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  tvgs_in_t               data_i,
  input  logic [IbWidth-1:0]     inv_beta_i,
  output logic                   valid_o,
  output logic [2*DataWidth-1:0] x_o,
  output logic [SideW-1:0]       side_o
);

  localparam int D    = DataWidth;
  localparam int Half = IbWidth / 2;
  localparam int Hi   = IbWidth - Half;
  localparam int PW   = D + IbWidth + 1;

  // stage a: products of |nu| with both halves of inv_beta
  logic [D-1:0]      an_h, an_v;
  logic              a_vld_q;
  logic [D+Half-1:0] plo_h_q, plo_v_q;
  logic [D+Hi-1:0]   phi_h_q, phi_v_q;
  logic [D-1:0]      w_h_q, w_v_q;
  logic              neg_h_q, neg_v_q;

  assign an_h = data_i.mult_h[D-1] ? D'(-data_i.mult_h) : data_i.mult_h;
  assign an_v = data_i.mult_v[D-1] ? D'(-data_i.mult_v) : data_i.mult_v;

  // stage b: rounded term, shifted vector with saturation
  logic [PW-1:0]     p_h, p_v, t_h, t_v, lim;
  logic [D+1:0]      tc_h, tc_v;
  logic signed [SatInW-1:0] s_h_w, s_v_w;
  logic [D:0]        sat_h, sat_v;
  logic              b_vld_q, b_flag_q;
  logic [D-1:0]      s_h_q, s_v_q;

  assign lim = PW'(1) << (D + 1);
  assign p_h = PW'(plo_h_q) + (PW'(phi_h_q) << Half) + (PW'(1) << (2*FRAC_BITS - 1));
  assign p_v = PW'(plo_v_q) + (PW'(phi_v_q) << Half) + (PW'(1) << (2*FRAC_BITS - 1));
  assign t_h = p_h >> (2*FRAC_BITS);
  assign t_v = p_v >> (2*FRAC_BITS);
  // any term beyond the limit saturates s regardless
  assign tc_h = (t_h > lim) ? lim[D+1:0] : t_h[D+1:0];
  assign tc_v = (t_v > lim) ? lim[D+1:0] : t_v[D+1:0];
  assign s_h_w = neg_h_q ? $signed({{4{w_h_q[D-1]}}, w_h_q}) + $signed({2'b00, tc_h})
                         : $signed({{4{w_h_q[D-1]}}, w_h_q}) - $signed({2'b00, tc_h});
  assign s_v_w = neg_v_q ? $signed({{4{w_v_q[D-1]}}, w_v_q}) + $signed({2'b00, tc_v})
                         : $signed({{4{w_v_q[D-1]}}, w_v_q}) - $signed({2'b00, tc_v});
  assign sat_h = sat_fn(s_h_w);
  assign sat_v = sat_fn(s_v_w);

  // stage c: magnitudes and squares
  logic [D-1:0]   ab_h, ab_v;
  logic           c_vld_q, c_flag_q, c_neg_h_q, c_neg_v_q;
  logic [D-1:0]   c_ab_h_q, c_ab_v_q;
  logic [2*D-1:0] sq_h_q, sq_v_q, sq_h, sq_v;

  assign ab_h = s_h_q[D-1] ? D'(-s_h_q) : s_h_q;
  assign ab_v = s_v_q[D-1] ? D'(-s_v_q) : s_v_q;
  assign sq_h = ab_h * ab_h;
  assign sq_v = ab_v * ab_v;

  // stage d: squared norm
  logic           d_vld_q;
  logic [2*D-1:0] x_q;
  logic [SideW-1:0] side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q <= valid_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      plo_h_q   <= an_h * inv_beta_i[Half-1:0];
      plo_v_q   <= an_v * inv_beta_i[Half-1:0];
      phi_h_q   <= an_h * inv_beta_i[IbWidth-1:Half];
      phi_v_q   <= an_v * inv_beta_i[IbWidth-1:Half];
      w_h_q     <= data_i.grad_h;
      w_v_q     <= data_i.grad_v;
      neg_h_q   <= data_i.mult_h[D-1];
      neg_v_q   <= data_i.mult_v[D-1];
      s_h_q     <= sat_h[D-1:0];
      s_v_q     <= sat_v[D-1:0];
      b_flag_q  <= sat_h[D] | sat_v[D];
      c_ab_h_q  <= ab_h;
      c_ab_v_q  <= ab_v;
      c_neg_h_q <= s_h_q[D-1];
      c_neg_v_q <= s_v_q[D-1];
      c_flag_q  <= b_flag_q;
      sq_h_q    <= sq_h;
      sq_v_q    <= sq_v;
      x_q       <= sq_h_q + sq_v_q;
      side_q    <= {c_ab_h_q, c_ab_v_q, c_neg_h_q, c_neg_v_q, c_flag_q};
    end
  end

  assign valid_o = d_vld_q;
  assign x_o     = x_q;
  assign side_o  = side_q;

endmodule

>>> src/tv_gradient_shrinkage_top.sv
// tv_gradient_shrinkage_top: isotropic / anisotropic tv shrinkage of one gradient pair
// depends on tvgs_pkg, tvgs_front, tvgs_sqrt_cell, tvgs_div_cell
//
//   channel   direction  beat / handshake                          payload
//   in        sink       in_valid_i, in_stall_o                    tvgs_in_t
//   out       source     out_valid_o, out_stall_i                  tvgs_out_t
//   config    apb        psel, penable, pwrite, paddr, pready      pwdata / prdata (64 bit)
//
// one beat per cycle sustained while in_stall_o is low. the path runs through the front
// end, a row of square-root cells (one per root bit), a scale stage and a row of divider
// cells (one per quotient bit). the whole cell row moves together; an output register plus
// one spare register let the row run one more beat while a result waits, after which
// in_stall_o rises. reset clears all valid bits and loads inv_beta = 1/64, isotropic mode.
module tv_gradient_shrinkage_top import tvgs_pkg::*; #(
  parameter int FRAC_BITS = FracBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tvgs_in_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tvgs_out_t           out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  localparam int D    = DataWidth;
  localparam int ThrW = IbWidth - FRAC_BITS + 1;
  localparam int CW   = ((D > ThrW) ? D : ThrW) + 1;

  // config registers
  logic [IbWidth-1:0] inv_beta_q;
  logic               mode_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_beta_q <= IbReset;
      mode_q     <= ModeIso;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3])
        AddrInvBeta: inv_beta_q <= pwdata[IbWidth-1:0];
        AddrMode:    mode_q     <= pwdata[0];
        default:     mode_q     <= mode_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[3])
      AddrInvBeta: prdata = ApbDataW'(inv_beta_q);
      AddrMode:    prdata = ApbDataW'(mode_q);
      default:     prdata = '0;
    endcase
  end

  // threshold, rounded to FRAC_BITS fraction bits
  logic [IbWidth:0] thr_full;
  logic [ThrW-1:0]  thr;
  assign thr_full = ({1'b0, inv_beta_q} + ((IbWidth+1)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
  assign thr      = thr_full[ThrW-1:0];

  // whole row advances while the spare register is free
  logic en;
  logic spare_vld_q, out_vld_q;
  assign en         = !spare_vld_q;
  assign in_stall_o = spare_vld_q;

  // front end: shifted vector and squared norm
  logic             f_vld;
  logic [2*D-1:0]   f_x;
  logic [SideW-1:0] f_side;

  tvgs_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (in_valid_i),
    .data_i     (in_data_i),
    .inv_beta_i (inv_beta_q),
    .valid_o    (f_vld),
    .x_o        (f_x),
    .side_o     (f_side)
  );

  // square-root cell row, most significant root bit first
  logic             sq_vld  [D+1];
  logic [2*D-1:0]   sq_x    [D+1];
  logic [D+1:0]     sq_rem  [D+1];
  logic [D-1:0]     sq_root [D+1];
  logic [SideW-1:0] sq_side [D+1];

  assign sq_vld[0]  = f_vld;
  assign sq_x[0]    = f_x;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_side[0] = f_side;

  for (genvar j = 0; j < D; j++) begin : g_sqrt
    tvgs_sqrt_cell #(.Idx(D - 1 - j)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_vld[j]),
      .x_i     (sq_x[j]),
      .rem_i   (sq_rem[j]),
      .root_i  (sq_root[j]),
      .side_i  (sq_side[j]),
      .valid_o (sq_vld[j+1]),
      .x_o     (sq_x[j+1]),
      .rem_o   (sq_rem[j+1]),
      .root_o  (sq_root[j+1]),
      .side_o  (sq_side[j+1])
    );
  end

  // scale stage: k = max(n - thr, 0), then |s| * k, then rounding half of n
  logic [D-1:0]     n_root, ab_h_r, ab_v_r, k_val;
  logic [CW-1:0]    nx, tx, kx;
  assign n_root = sq_root[D];
  assign ab_h_r = sq_side[D][SideW-1 -: D];
  assign ab_v_r = sq_side[D][SideW-1-D -: D];
  assign nx     = CW'(n_root);
  assign tx     = CW'(thr);
  assign kx     = (nx > tx) ? (nx - tx) : '0;
  assign k_val  = kx[D-1:0];

  logic             m1_vld_q, m2_vld_q;
  logic [2*D-1:0]   m1_ph_q, m1_pv_q;
  logic [D-1:0]     m1_n_q, m2_n_q;
  logic [SideW-1:0] m1_side_q, m2_side_q;
  logic [2*D:0]     m2_nh_q, m2_nv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_vld_q <= 1'b0;
      m2_vld_q <= 1'b0;
    end else if (en) begin
      m1_vld_q <= sq_vld[D];
      m2_vld_q <= m1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_ph_q   <= ab_h_r * k_val;
      m1_pv_q   <= ab_v_r * k_val;
      m1_n_q    <= n_root;
      m1_side_q <= sq_side[D];
      m2_nh_q   <= (2*D+1)'(m1_ph_q) + (2*D+1)'(m1_n_q >> 1);
      m2_nv_q   <= (2*D+1)'(m1_pv_q) + (2*D+1)'(m1_n_q >> 1);
      m2_n_q    <= m1_n_q;
      m2_side_q <= m1_side_q;
    end
  end

  // divider cell row, one quotient bit per cell from the top
  logic             dv_vld  [D+2];
  logic [D-1:0]     dv_n    [D+2];
  logic [2*D:0]     dv_nh   [D+2];
  logic [2*D:0]     dv_nv   [D+2];
  logic [D-1:0]     dv_rh   [D+2];
  logic [D-1:0]     dv_rv   [D+2];
  logic [D:0]       dv_qh   [D+2];
  logic [D:0]       dv_qv   [D+2];
  logic [SideW-1:0] dv_side [D+2];

  assign dv_vld[0]  = m2_vld_q;
  assign dv_n[0]    = m2_n_q;
  assign dv_nh[0]   = m2_nh_q;
  assign dv_nv[0]   = m2_nv_q;
  assign dv_rh[0]   = m2_nh_q[2*D:D+1];
  assign dv_rv[0]   = m2_nv_q[2*D:D+1];
  assign dv_qh[0]   = '0;
  assign dv_qv[0]   = '0;
  assign dv_side[0] = m2_side_q;

  for (genvar j = 0; j <= D; j++) begin : g_div
    tvgs_div_cell #(.Bit(D - j)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_vld[j]),
      .n_i     (dv_n[j]),
      .num_h_i (dv_nh[j]),
      .num_v_i (dv_nv[j]),
      .rem_h_i (dv_rh[j]),
      .rem_v_i (dv_rv[j]),
      .q_h_i   (dv_qh[j]),
      .q_v_i   (dv_qv[j]),
      .side_i  (dv_side[j]),
      .valid_o (dv_vld[j+1]),
      .n_o     (dv_n[j+1]),
      .num_h_o (dv_nh[j+1]),
      .num_v_o (dv_nv[j+1]),
      .rem_h_o (dv_rh[j+1]),
      .rem_v_o (dv_rv[j+1]),
      .q_h_o   (dv_qh[j+1]),
      .q_v_o   (dv_qv[j+1]),
      .side_o  (dv_side[j+1])
    );
  end

  // result: pick mode, apply sign, saturate
  logic [SideW-1:0] fs;
  logic [D-1:0]     f_ab_h, f_ab_v, f_n;
  logic             f_neg_h, f_neg_v, f_flag, last_vld;
  logic [CW-1:0]    ah_x, av_x, mh_x, mv_x;
  logic signed [SatInW-1:0] val_h, val_v, mag_h, mag_v;
  logic [D:0]       r_h, r_v;
  tvgs_out_t        res;

  assign last_vld = dv_vld[D+1];
  assign fs       = dv_side[D+1];
  assign f_ab_h   = fs[SideW-1 -: D];
  assign f_ab_v   = fs[SideW-1-D -: D];
  assign f_neg_h  = fs[2];
  assign f_neg_v  = fs[1];
  assign f_flag   = fs[0];
  assign f_n      = dv_n[D+1];

  assign ah_x = CW'(f_ab_h);
  assign av_x = CW'(f_ab_v);
  assign mh_x = (ah_x > tx) ? (ah_x - tx) : '0;
  assign mv_x = (av_x > tx) ? (av_x - tx) : '0;

  always_comb begin
    if (mode_q == ModeAniso) begin
      mag_h = SatInW'(mh_x[D-1:0]);
      mag_v = SatInW'(mv_x[D-1:0]);
    end else if (f_n == '0) begin
      // zero norm gives a zero vector
      mag_h = '0;
      mag_v = '0;
    end else begin
      mag_h = SatInW'(dv_qh[D+1]);
      mag_v = SatInW'(dv_qv[D+1]);
    end
    val_h = f_neg_h ? -mag_h : mag_h;
    val_v = f_neg_v ? -mag_v : mag_v;
  end

  assign r_h          = sat_fn(val_h);
  assign r_v          = sat_fn(val_v);
  assign res.shrunk_h = r_h[D-1:0];
  assign res.shrunk_v = r_v[D-1:0];
  assign res.clipped  = f_flag | r_h[D] | r_v[D];

  // output register with one spare behind it
  tvgs_out_t out_q, spare_q;
  logic      out_take;
  assign out_take = out_vld_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q   <= 1'b0;
      spare_vld_q <= 1'b0;
    end else if (spare_vld_q) begin
      if (out_take) begin
        spare_vld_q <= 1'b0;
      end
    end else if (last_vld) begin
      if (!out_vld_q || out_take) begin
        out_vld_q <= 1'b1;
      end else begin
        spare_vld_q <= 1'b1;
      end
    end else if (out_take) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (spare_vld_q) begin
      if (out_take) begin
        out_q <= spare_q;
      end
    end else if (last_vld) begin
      if (!out_vld_q || out_take) begin
        out_q <= res;
      end else begin
        spare_q <= res;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // spare only fills behind a waiting result
  a_spare_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    spare_vld_q |-> out_vld_q) else $error("spare beat without output beat");

  // a parked beat is not overwritten while the output is stalled
  a_spare_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (spare_vld_q && out_stall_i) |=> (spare_vld_q && $stable(spare_q)))
    else $error("spare beat lost");

  // isotropic zero norm yields zero components
  a_zero_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last_vld && mode_q == ModeIso && f_n == '0) |-> (res.shrunk_h == '0 &&
    res.shrunk_v == '0)) else $error("nonzero result at zero norm");

  // a parked spare beat is not released until the output beat is taken
  a_frozen_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (spare_vld_q && !out_take) |=> spare_vld_q)
    else $error("spare released without output taken");
`endif

endmodule
